// ===== rtl/rmrt_pkg.sv =====
package rmrt_pkg;

    // Command codes carried in tuser
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_MODE  = 2'd1,
        CMD_AUTO  = 2'd2,
        CMD_NIGHT = 2'd3
    } cmd_t;

    // Switch modes
    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_AUTO = 2'd1,
        MODE_TEMP = 2'd2,
        MODE_ON   = 2'd3
    } mode_t;

    // Configuration register indexes
    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_LAMP    = 1'b1;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 9;
    localparam int TMO_W      = 9;
    localparam int ELAPSED_W  = 10;
    localparam int MS_W       = 32;
    localparam int S_DATA_W   = 16;
    localparam int M_DATA_W   = 168;

    localparam logic [TMO_W-1:0] TMO_RESET   = 9'd60;
    localparam logic [MS_W-1:0]  MS_PER_MIN  = 32'd60000;
    localparam logic [MS_W-1:0]  HALF_SECOND = 32'd500;

    // x / 1000 == (x * DIV_RECIP) >> DIV_SHIFT for every 32-bit x
    localparam int               RECIP_W   = 29;
    localparam int               PROD_W    = MS_W + RECIP_W;
    localparam int               DIV_SHIFT = 38;
    localparam int               QUOT_W    = PROD_W - DIV_SHIFT;
    localparam logic [RECIP_W-1:0] DIV_RECIP = 29'h10624DD3;

    // Per-item snapshot of the state right after the update
    typedef struct packed {
        logic            relay_on;
        mode_t           mode;
        logic            auto_on;
        logic [MS_W-1:0] diff_ms;
        logic [MS_W-1:0] last_run_ms;
        logic [MS_W-1:0] today_ms;
        logic            close;
        logic [MS_W-1:0] close_ms;
    } snap_t;

    // Sums ready for the divide by 1000
    typedef struct packed {
        logic            relay_on;
        mode_t           mode;
        logic            auto_on;
        logic [MS_W-1:0] running_ms;
        logic [MS_W-1:0] pausing_ms;
        logic [MS_W-1:0] last_run_ms;
        logic [MS_W-1:0] today_sum;
        logic            close;
        logic [MS_W-1:0] close_sum;
    } sum_t;

    // Reciprocal products
    typedef struct packed {
        logic              relay_on;
        mode_t             mode;
        logic              auto_on;
        logic [MS_W-1:0]   running_ms;
        logic [MS_W-1:0]   pausing_ms;
        logic [MS_W-1:0]   last_run_ms;
        logic [PROD_W-1:0] today_prod;
        logic              close;
        logic [PROD_W-1:0] close_prod;
    } prod_t;

endpackage

// ===== rtl/rmrt_ctrl.sv =====
// Mode, relay and run-time state; updated once per accepted request
module rmrt_ctrl
    import rmrt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_accept,
    input  cmd_t                  in_cmd,
    input  logic [ELAPSED_W-1:0]  in_elapsed_ms,
    input  logic [1:0]            in_new_mode,
    input  logic                  in_auto_request,
    input  logic                  in_is_night,
    output snap_t                 snap
);

    logic [TMO_W-1:0] timeout_reg;
    logic             lamp_reg;

    logic [MS_W-1:0] now_reg, now_next;
    logic [MS_W-1:0] sw_reg, sw_next;
    logic [MS_W-1:0] deadline_reg, deadline_next;
    mode_t           mode_reg, mode_next;
    mode_t           ret_reg, ret_next;
    logic            auto_reg, auto_next;
    logic            relay_reg, relay_next;
    logic [MS_W-1:0] run_reg, run_next;
    logic [MS_W-1:0] today_reg, today_next;

    logic [MS_W-1:0] now_tick, dl_gap, span, today_book, tmo_ms;
    logic            req, set_req, want, close, do_sw, book, restart;
    mode_t           req_mode;

    assign tmo_ms = MS_W'(timeout_reg) * MS_PER_MIN;

    // Next-state logic for one request
    always_comb begin
        now_tick      = now_reg + MS_W'(in_elapsed_ms);
        now_next      = (in_cmd == CMD_TICK) ? now_tick : now_reg;
        dl_gap        = now_tick - deadline_reg;
        deadline_next = deadline_reg;
        mode_next     = mode_reg;
        ret_next      = ret_reg;
        auto_next     = auto_reg;
        req           = 1'b0;
        req_mode      = mode_t'(in_new_mode);
        set_req       = 1'b0;
        want          = 1'b0;
        close         = 1'b0;

        case (in_cmd)
            CMD_TICK: begin
                // temporary mode ends once the deadline is reached
                if (mode_reg == MODE_TEMP && !dl_gap[MS_W-1]) begin
                    req      = 1'b1;
                    req_mode = ret_reg;
                end
            end
            CMD_MODE: begin
                req = 1'b1;
            end
            CMD_AUTO: begin
                if (auto_reg != in_auto_request) begin
                    auto_next = in_auto_request;
                    if (mode_reg == MODE_AUTO) begin
                        set_req = 1'b1;
                        want    = in_auto_request;
                    end
                end
            end
            CMD_NIGHT: begin
                close = lamp_reg ? in_is_night : !in_is_night;
            end
            default: begin
                req = 1'b0;
            end
        endcase

        // mode request: deadline always restarts
        if (req) begin
            deadline_next = now_next + tmo_ms;
            if (mode_reg != req_mode) begin
                case (req_mode)
                    MODE_OFF:  want = 1'b0;
                    MODE_AUTO: want = auto_reg;
                    default:   want = 1'b1;
                endcase
                if (mode_reg inside {MODE_OFF, MODE_AUTO}) begin
                    ret_next = mode_reg;
                end
                mode_next = req_mode;
                set_req   = 1'b1;
            end
        end

        // relay switching and run booking
        do_sw      = set_req && (relay_reg != want);
        relay_next = do_sw ? want : relay_reg;
        span       = now_next - sw_reg;
        book       = (do_sw && !want) || (close && relay_reg);
        restart    = do_sw || (close && relay_reg);
        run_next   = book ? span : run_reg;
        today_book = book ? today_reg + span : today_reg;
        today_next = close ? '0 : today_book;
        sw_next    = restart ? now_next : sw_reg;
    end

    always_comb begin
        snap.relay_on    = relay_next;
        snap.mode        = mode_next;
        snap.auto_on     = auto_next;
        snap.diff_ms     = restart ? '0 : span;
        snap.last_run_ms = run_next;
        snap.today_ms    = today_next;
        snap.close       = close;
        snap.close_ms    = today_book;
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TMO_RESET;
            lamp_reg    <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_TIMEOUT: timeout_reg <= cfg_wdata[TMO_W-1:0];
                CFG_LAMP:    lamp_reg    <= cfg_wdata[0];
                default:     lamp_reg    <= lamp_reg;
            endcase
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_reg      <= '0;
            sw_reg       <= '0;
            deadline_reg <= '0;
            mode_reg     <= MODE_AUTO;
            ret_reg      <= MODE_AUTO;
            auto_reg     <= 1'b0;
            relay_reg    <= 1'b0;
            run_reg      <= '0;
            today_reg    <= '0;
        end else if (in_accept) begin
            now_reg      <= now_next;
            sw_reg       <= sw_next;
            deadline_reg <= deadline_next;
            mode_reg     <= mode_next;
            ret_reg      <= ret_next;
            auto_reg     <= auto_next;
            relay_reg    <= relay_next;
            run_reg      <= run_next;
            today_reg    <= today_next;
        end
    end

    // Relay always matches what the mode asks for
    a_relay_matches_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        relay_reg == ((mode_reg == MODE_ON) || (mode_reg == MODE_TEMP) ||
                      ((mode_reg == MODE_AUTO) && auto_reg)))
        else $error("relay state disagrees with mode");

    // Saved return mode is off or auto only
    a_return_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (ret_reg == MODE_OFF) || (ret_reg == MODE_AUTO))
        else $error("return mode is not off or auto");

endmodule

// ===== rtl/relay_mode_runtime_tracker_top.sv =====
// An accepted request passes the s1, s2, s3 and output registers to m_tvalid.
// Throughput: one request per cycle; state updates at accept, the divide by
// 1000 is a reciprocal multiply spread over three further pipeline stages.
// Backpressure fills the pipeline bubbles first, then holds s_tready low.
// Reset (aresetn low, synchronous): mode auto, relay off, all counters zero,
// timeout 60 minutes, lamp reference 0, pipeline empty.
module relay_mode_runtime_tracker_top
    import rmrt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // request channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // elapsed_ms[9:0], new_mode[11:10],
                                             // auto_request[12], is_night[13]
    input  logic [1:0]            s_tuser,   // cmd[1:0]
    // result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata    // relay_on[0], mode[2:1], auto_on[3],
                                             // running_ms[35:4], pausing_ms[67:36],
                                             // last_run_ms[99:68],
                                             // today_seconds[131:100],
                                             // total_seconds[163:132]
);

    logic  s_accept;
    snap_t snap;

    logic  v1_reg, v2_reg, v3_reg, v4_reg;
    logic  en1, en2, en3, en4;
    snap_t s1_reg;
    sum_t  s2_reg, s2_next;
    prod_t s3_reg, s3_next;

    logic [MS_W-1:0]   total_reg, total_next;
    logic [QUOT_W-1:0] q_today, q_close;
    logic [MS_W-1:0]   out_today, out_total;

    logic              o_relay_reg, o_auto_reg;
    mode_t             o_mode_reg;
    logic [MS_W-1:0]   o_running_reg, o_pausing_reg, o_last_run_reg;
    logic [MS_W-1:0]   o_today_reg, o_total_reg;

    // Stage enables: a stage moves when empty or when its successor moves
    assign en4      = !v4_reg || m_tready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;
    assign s_accept = s_tvalid && s_tready;

    rmrt_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .in_accept       (s_accept),
        .in_cmd          (cmd_t'(s_tuser)),
        .in_elapsed_ms   (s_tdata[ELAPSED_W-1:0]),
        .in_new_mode     (s_tdata[11:10]),
        .in_auto_request (s_tdata[12]),
        .in_is_night     (s_tdata[13]),
        .snap            (snap)
    );

    // Stage 2: run/pause split and rounding sums
    always_comb begin
        s2_next.relay_on    = s1_reg.relay_on;
        s2_next.mode        = s1_reg.mode;
        s2_next.auto_on     = s1_reg.auto_on;
        s2_next.running_ms  = s1_reg.relay_on ? s1_reg.diff_ms : '0;
        s2_next.pausing_ms  = s1_reg.relay_on ? '0 : s1_reg.diff_ms;
        s2_next.last_run_ms = s1_reg.last_run_ms;
        s2_next.today_sum   = s1_reg.today_ms + s2_next.running_ms + HALF_SECOND;
        s2_next.close       = s1_reg.close;
        s2_next.close_sum   = s1_reg.close_ms + HALF_SECOND;
    end

    // Stage 3: reciprocal multiplies
    always_comb begin
        s3_next.relay_on    = s2_reg.relay_on;
        s3_next.mode        = s2_reg.mode;
        s3_next.auto_on     = s2_reg.auto_on;
        s3_next.running_ms  = s2_reg.running_ms;
        s3_next.pausing_ms  = s2_reg.pausing_ms;
        s3_next.last_run_ms = s2_reg.last_run_ms;
        s3_next.today_prod  = PROD_W'(s2_reg.today_sum) * PROD_W'(DIV_RECIP);
        s3_next.close       = s2_reg.close;
        s3_next.close_prod  = PROD_W'(s2_reg.close_sum) * PROD_W'(DIV_RECIP);
    end

    // Stage 4: quotients and running total
    assign q_today    = s3_reg.today_prod[PROD_W-1:DIV_SHIFT];
    assign q_close    = s3_reg.close_prod[PROD_W-1:DIV_SHIFT];
    assign total_next = total_reg + (s3_reg.close ? MS_W'(q_close) : '0);
    assign out_today  = MS_W'(q_today);
    assign out_total  = total_next + out_today;

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            total_reg <= '0;
        end else begin
            if (en1) v1_reg <= s_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en4 && v3_reg) total_reg <= total_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) s1_reg <= snap;
        if (en2 && v1_reg) s2_reg <= s2_next;
        if (en3 && v2_reg) s3_reg <= s3_next;
        if (en4 && v3_reg) begin
            o_relay_reg    <= s3_reg.relay_on;
            o_mode_reg     <= s3_reg.mode;
            o_auto_reg     <= s3_reg.auto_on;
            o_running_reg  <= s3_reg.running_ms;
            o_pausing_reg  <= s3_reg.pausing_ms;
            o_last_run_reg <= s3_reg.last_run_ms;
            o_today_reg    <= out_today;
            o_total_reg    <= out_total;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {4'b0, o_total_reg, o_today_reg, o_last_run_reg,
                       o_pausing_reg, o_running_reg, o_auto_reg, o_mode_reg,
                       o_relay_reg};

    // Input side only stalls when the whole pipeline is full and blocked
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (v1_reg && v2_reg && v3_reg && v4_reg && !m_tready))
        else $error("request stalled with room in the pipeline");

    // Total only moves when a result enters the output stage
    a_total_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        !(en4 && v3_reg) |=> $stable(total_reg))
        else $error("total changed without a result advancing");

    // A stalled result does not lose its total
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(o_total_reg)))
        else $error("stalled result changed");

endmodule
